@@ src/iie_pkg.sv @@
// shared types, constants and flag helpers for the implied-instruction executor
package iie_pkg;

    localparam int CMD_W   = 5;
    localparam int DATA_W  = 8;
    localparam int PC_W    = 16;
    localparam int CYC_W   = 3;
    localparam int STK_AW  = 8;
    localparam int STK_DEPTH = 1 << STK_AW;

    // status bit positions, N V 1 B D I Z C
    localparam int FLG_C = 0;
    localparam int FLG_Z = 1;
    localparam int FLG_I = 2;
    localparam int FLG_D = 3;
    localparam int FLG_B = 4;
    localparam int FLG_U = 5;
    localparam int FLG_V = 6;
    localparam int FLG_N = 7;

    localparam logic [DATA_W-1:0] SP_RST     = 8'hFD;
    localparam logic [DATA_W-1:0] STATUS_RST = 8'h24;
    localparam logic [DATA_W-1:0] PUSH_BU    = 8'h30;
    localparam logic [PC_W-1:0]   VEC_RST    = 16'h0000;

    localparam logic [CYC_W-1:0] CYC_IMPL = 3'd2;
    localparam logic [CYC_W-1:0] CYC_PUSH = 3'd3;
    localparam logic [CYC_W-1:0] CYC_PULL = 3'd4;
    localparam logic [CYC_W-1:0] CYC_RET  = 3'd6;
    localparam logic [CYC_W-1:0] CYC_BRK  = 3'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_BRK = 5'd0,  CMD_CLC = 5'd1,  CMD_CLD = 5'd2,  CMD_CLI = 5'd3,
        CMD_CLV = 5'd4,  CMD_DEX = 5'd5,  CMD_DEY = 5'd6,  CMD_INX = 5'd7,
        CMD_INY = 5'd8,  CMD_NOP = 5'd9,  CMD_PHA = 5'd10, CMD_PHP = 5'd11,
        CMD_PLA = 5'd12, CMD_PLP = 5'd13, CMD_RTI = 5'd14, CMD_RTS = 5'd15,
        CMD_SEC = 5'd16, CMD_SED = 5'd17, CMD_SEI = 5'd18, CMD_TAX = 5'd19,
        CMD_TAY = 5'd20, CMD_TSX = 5'd21, CMD_TXA = 5'd22, CMD_TXS = 5'd23,
        CMD_TYA = 5'd24
    } t_cmd;

    // one stack access per cycle: a write port and a read port
    typedef struct packed {
        logic              we;
        logic [STK_AW-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [STK_AW-1:0] raddr;
    } t_stk_req;

    function automatic logic [DATA_W-1:0] f_set_zn(input logic [DATA_W-1:0] p,
                                                   input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r        = p;
        r[FLG_Z] = (v == '0);
        r[FLG_N] = v[DATA_W-1];
        return r;
    endfunction

    // pulled status: B dropped, bit 5 forced
    function automatic logic [DATA_W-1:0] f_load_status(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r        = v;
        r[FLG_B] = 1'b0;
        r[FLG_U] = 1'b1;
        return r;
    endfunction

    function automatic logic [CYC_W-1:0] f_cycles(input t_cmd c);
        logic [CYC_W-1:0] r;
        case (c) inside
            CMD_BRK:          r = CYC_BRK;
            CMD_PHA, CMD_PHP: r = CYC_PUSH;
            CMD_PLA, CMD_PLP: r = CYC_PULL;
            CMD_RTI, CMD_RTS: r = CYC_RET;
            default:          r = CYC_IMPL;
        endcase
        return r;
    endfunction

endpackage

@@ src/iie_stack_ram.sv @@
// 256-byte stack page: synchronous RAM with per-entry valid bits, unwritten reads as zero
module iie_stack_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iie_pkg::t_stk_req             i_req,
    output logic [iie_pkg::DATA_W-1:0]    o_rdata
);
    import iie_pkg::*;

    logic [DATA_W-1:0]    r_mem [STK_DEPTH];
    logic [STK_DEPTH-1:0] r_valid;
    logic [DATA_W-1:0]    r_rd;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rd : '0;

endmodule

@@ src/implied_instruction_execute_8bit_cpu.sv @@
// top level: implied-instruction executor with register file and stack RAM
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_command, i_pc_in
//  out     | output    | o_out_valid/i_out_stall | o_acc_out .. o_cycle_count
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (brk vector)
//
//  one beat per cycle for register ops and PHA/PHP if out does not stall;
//  PLA/PLP end in S1, BRK/RTS in S2, RTI in S3; one stack access per cycle.
//  a new beat is taken in the cycle the previous instruction finishes.
//  reset (sync, active low) loads A/X/Y=0, SP=FD, P=24, vector 0; the stack
//  valid bits clear at once, so there is no clearing pass.
//  a stalled result holds in the output register and freezes the engine.
module implied_instruction_execute_8bit_cpu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [iie_pkg::CMD_W-1:0]     i_command,
    input  logic [iie_pkg::PC_W-1:0]      i_pc_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [iie_pkg::DATA_W-1:0]    o_acc_out,
    output logic [iie_pkg::DATA_W-1:0]    o_x_out,
    output logic [iie_pkg::DATA_W-1:0]    o_y_out,
    output logic [iie_pkg::DATA_W-1:0]    o_sp_out,
    output logic [iie_pkg::DATA_W-1:0]    o_flags_out,
    output logic [iie_pkg::PC_W-1:0]      o_pc_next,
    output logic [iie_pkg::CYC_W-1:0]     o_cycle_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [iie_pkg::PC_W-1:0]      i_cfg_data
);
    import iie_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_S0   = 5'b00010,
        PH_S1   = 5'b00100,
        PH_S2   = 5'b01000,
        PH_S3   = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    t_cmd              r_cmd;
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   r_vec;
    logic [DATA_W-1:0] r_a, r_x, r_y, r_sp, r_p, r_lo;
    logic [DATA_W-1:0] n_a, n_x, n_y, n_sp, n_p, n_lo;
    logic [PC_W-1:0]   pc_nxt;
    logic [PC_W-1:0]   pc_plus2;
    logic              r_ov;

    logic              busy;
    logic              go;
    logic              last;
    logic              in_acc;
    t_stk_req          req;
    logic [DATA_W-1:0] rd;

    assign busy     = (r_phase != PH_IDLE);
    assign go       = busy && (!r_ov || !i_out_stall);
    assign o_in_stall = busy && !(go && last);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign pc_plus2 = r_pc + 16'd2;

    iie_stack_ram u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rd)
    );

    always_comb begin
        n_a     = r_a;
        n_x     = r_x;
        n_y     = r_y;
        n_sp    = r_sp;
        n_p     = r_p;
        n_lo    = r_lo;
        n_phase = r_phase;
        pc_nxt  = r_pc + 16'd1;
        last    = 1'b0;
        req.we    = 1'b0;
        req.waddr = r_sp;
        req.wdata = r_a;
        req.re    = 1'b0;
        req.raddr = r_sp + 8'd1;

        unique case (r_phase)
            PH_S0: begin
                unique case (r_cmd)
                    CMD_BRK: begin
                        req.we    = 1'b1;
                        req.wdata = pc_plus2[PC_W-1:DATA_W];
                        n_sp      = r_sp - 8'd1;
                        n_phase   = PH_S1;
                    end
                    CMD_CLC: begin n_p[FLG_C] = 1'b0; last = 1'b1; end
                    CMD_CLD: begin n_p[FLG_D] = 1'b0; last = 1'b1; end
                    CMD_CLI: begin n_p[FLG_I] = 1'b0; last = 1'b1; end
                    CMD_CLV: begin n_p[FLG_V] = 1'b0; last = 1'b1; end
                    CMD_SEC: begin n_p[FLG_C] = 1'b1; last = 1'b1; end
                    CMD_SED: begin n_p[FLG_D] = 1'b1; last = 1'b1; end
                    CMD_SEI: begin n_p[FLG_I] = 1'b1; last = 1'b1; end
                    CMD_DEX: begin
                        n_x = r_x - 8'd1; n_p = f_set_zn(r_p, n_x); last = 1'b1;
                    end
                    CMD_DEY: begin
                        n_y = r_y - 8'd1; n_p = f_set_zn(r_p, n_y); last = 1'b1;
                    end
                    CMD_INX: begin
                        n_x = r_x + 8'd1; n_p = f_set_zn(r_p, n_x); last = 1'b1;
                    end
                    CMD_INY: begin
                        n_y = r_y + 8'd1; n_p = f_set_zn(r_p, n_y); last = 1'b1;
                    end
                    CMD_TAX: begin n_x = r_a;  n_p = f_set_zn(r_p, r_a);  last = 1'b1; end
                    CMD_TAY: begin n_y = r_a;  n_p = f_set_zn(r_p, r_a);  last = 1'b1; end
                    CMD_TSX: begin n_x = r_sp; n_p = f_set_zn(r_p, r_sp); last = 1'b1; end
                    CMD_TXA: begin n_a = r_x;  n_p = f_set_zn(r_p, r_x);  last = 1'b1; end
                    CMD_TYA: begin n_a = r_y;  n_p = f_set_zn(r_p, r_y);  last = 1'b1; end
                    CMD_TXS: begin n_sp = r_x; last = 1'b1; end
                    CMD_PHA: begin
                        req.we    = 1'b1;
                        req.wdata = r_a;
                        n_sp      = r_sp - 8'd1;
                        last      = 1'b1;
                    end
                    CMD_PHP: begin
                        req.we    = 1'b1;
                        req.wdata = r_p | PUSH_BU;
                        n_sp      = r_sp - 8'd1;
                        last      = 1'b1;
                    end
                    CMD_PLA, CMD_PLP, CMD_RTI, CMD_RTS: begin
                        req.re  = 1'b1;
                        n_sp    = r_sp + 8'd1;
                        n_phase = PH_S1;
                    end
                    default: last = 1'b1;   // NOP and undefined codes
                endcase
            end
            PH_S1: begin
                unique case (r_cmd)
                    CMD_BRK: begin
                        req.we    = 1'b1;
                        req.wdata = pc_plus2[DATA_W-1:0];
                        n_sp      = r_sp - 8'd1;
                        n_phase   = PH_S2;
                    end
                    CMD_PLA: begin
                        n_a  = rd;
                        n_p  = f_set_zn(r_p, rd);
                        last = 1'b1;
                    end
                    CMD_PLP: begin
                        n_p  = f_load_status(rd);
                        last = 1'b1;
                    end
                    CMD_RTI: begin
                        n_p     = f_load_status(rd);
                        req.re  = 1'b1;
                        n_sp    = r_sp + 8'd1;
                        n_phase = PH_S2;
                    end
                    CMD_RTS: begin
                        n_lo    = rd;
                        req.re  = 1'b1;
                        n_sp    = r_sp + 8'd1;
                        n_phase = PH_S2;
                    end
                    default: last = 1'b1;
                endcase
            end
            PH_S2: begin
                unique case (r_cmd)
                    CMD_BRK: begin
                        // status pushed before I is set
                        req.we     = 1'b1;
                        req.wdata  = r_p | PUSH_BU;
                        n_sp       = r_sp - 8'd1;
                        n_p[FLG_I] = 1'b1;
                        pc_nxt     = r_vec;
                        last       = 1'b1;
                    end
                    CMD_RTI: begin
                        n_lo    = rd;
                        req.re  = 1'b1;
                        n_sp    = r_sp + 8'd1;
                        n_phase = PH_S3;
                    end
                    CMD_RTS: begin
                        pc_nxt = {rd, r_lo} + 16'd1;
                        last   = 1'b1;
                    end
                    default: last = 1'b1;
                endcase
            end
            PH_S3: begin
                pc_nxt = {rd, r_lo};
                last   = 1'b1;
            end
            PH_IDLE: begin
                last = 1'b0;
            end
            default: begin
                last = 1'b0;
            end
        endcase

        // nothing reaches the RAM while the engine is frozen
        req.we = req.we && go;
        req.re = req.re && go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_a     <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_sp    <= SP_RST;
            r_p     <= STATUS_RST;
            r_vec   <= VEC_RST;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vec <= i_cfg_data;
            end
            if (go) begin
                r_a  <= n_a;
                r_x  <= n_x;
                r_y  <= n_y;
                r_sp <= n_sp;
                r_p  <= n_p;
            end
            if (in_acc) begin
                r_phase <= PH_S0;
            end else if (go && last) begin
                r_phase <= PH_IDLE;
            end else if (go) begin
                r_phase <= n_phase;
            end
            if (go && last) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= t_cmd'(i_command);
            r_pc  <= i_pc_in;
        end
        if (go) begin
            r_lo <= n_lo;
        end
        if (go && last) begin
            o_acc_out     <= n_a;
            o_x_out       <= n_x;
            o_y_out       <= n_y;
            o_sp_out      <= n_sp;
            o_flags_out   <= n_p;
            o_pc_next     <= pc_nxt;
            o_cycle_count <= f_cycles(r_cmd);
        end
    end

    assign o_out_valid = r_ov;

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the implied-instruction executor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iie_pkg::*;

    localparam int          RESET_CYCLES = 8;
    localparam int          PHASE_ITEMS  = 430;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // codes past TYA decode as NOP
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 5'd25;
    localparam logic [CMD_W-1:0] CMD_UNUSED_TOP = 5'd31;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] sp;
        logic [DATA_W-1:0] flags;
        logic [PC_W-1:0]   pc_next;
        logic [CYC_W-1:0]  cycles;
    } t_retire;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [PC_W-1:0]  pc;
        bit               typed;
        t_retire          want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [PC_W-1:0]     i_pc_in;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [DATA_W-1:0]   o_acc_out;
    logic [DATA_W-1:0]   o_x_out;
    logic [DATA_W-1:0]   o_y_out;
    logic [DATA_W-1:0]   o_sp_out;
    logic [DATA_W-1:0]   o_flags_out;
    logic [PC_W-1:0]     o_pc_next;
    logic [CYC_W-1:0]    o_cycle_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [PC_W-1:0]     i_cfg_data;

    // predicted cpu state
    logic [DATA_W-1:0]   reg_a;
    logic [DATA_W-1:0]   reg_x;
    logic [DATA_W-1:0]   reg_y;
    logic [DATA_W-1:0]   reg_s;
    logic [DATA_W-1:0]   reg_p;
    logic [DATA_W-1:0]   stack_ram [STK_DEPTH];
    logic [PC_W-1:0]     brk_vec;

    t_retire             expected_regs [$];
    t_dir_row            directed_rows [$];
    int unsigned         src_idle_pct;
    int unsigned         snk_idle_pct;
    int unsigned         bad_fields;
    int unsigned         cycle_ticks;

    implied_instruction_execute_8bit_cpu uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_pc_in       (i_pc_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_acc_out     (o_acc_out),
        .o_x_out       (o_x_out),
        .o_y_out       (o_y_out),
        .o_sp_out      (o_sp_out),
        .o_flags_out   (o_flags_out),
        .o_pc_next     (o_pc_next),
        .o_cycle_count (o_cycle_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void push_stack(input logic [DATA_W-1:0] v);
        stack_ram[reg_s] = v;
        reg_s = reg_s - 8'd1;
    endfunction

    function automatic logic [DATA_W-1:0] pull_stack();
        reg_s = reg_s + 8'd1;
        return stack_ram[reg_s];
    endfunction

    function automatic logic [DATA_W-1:0] with_zn(input logic [DATA_W-1:0] v);
        reg_p[FLG_Z] = (v == '0);
        reg_p[FLG_N] = v[DATA_W-1];
        return v;
    endfunction

    function automatic void pulled_status(input logic [DATA_W-1:0] v);
        reg_p        = v;
        reg_p[FLG_B] = 1'b0;
        reg_p[FLG_U] = 1'b1;
    endfunction

    // advance the predicted cpu by one instruction and return its registers
    function automatic t_retire exec_implied(input logic [CMD_W-1:0] cmd,
                                             input logic [PC_W-1:0] pc);
        t_retire           r;
        logic [PC_W-1:0]   ret_addr;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        r.pc_next = pc + 16'd1;
        r.cycles  = CYC_IMPL;
        case (cmd)
            CMD_BRK: begin
                ret_addr = pc + 16'd2;
                push_stack(ret_addr[15:8]);
                push_stack(ret_addr[7:0]);
                push_stack(reg_p | PUSH_BU);
                reg_p[FLG_I] = 1'b1;
                r.pc_next = brk_vec;
                r.cycles  = CYC_BRK;
            end
            CMD_CLC: reg_p[FLG_C] = 1'b0;
            CMD_CLD: reg_p[FLG_D] = 1'b0;
            CMD_CLI: reg_p[FLG_I] = 1'b0;
            CMD_CLV: reg_p[FLG_V] = 1'b0;
            CMD_DEX: reg_x = with_zn(reg_x - 8'd1);
            CMD_DEY: reg_y = with_zn(reg_y - 8'd1);
            CMD_INX: reg_x = with_zn(reg_x + 8'd1);
            CMD_INY: reg_y = with_zn(reg_y + 8'd1);
            CMD_PHA: begin
                push_stack(reg_a);
                r.cycles = CYC_PUSH;
            end
            CMD_PHP: begin
                push_stack(reg_p | PUSH_BU);
                r.cycles = CYC_PUSH;
            end
            CMD_PLA: begin
                reg_a = with_zn(pull_stack());
                r.cycles = CYC_PULL;
            end
            CMD_PLP: begin
                pulled_status(pull_stack());
                r.cycles = CYC_PULL;
            end
            CMD_RTI: begin
                pulled_status(pull_stack());
                lo = pull_stack();
                hi = pull_stack();
                r.pc_next = {hi, lo};
                r.cycles  = CYC_RET;
            end
            CMD_RTS: begin
                lo = pull_stack();
                hi = pull_stack();
                r.pc_next = {hi, lo} + 16'd1;
                r.cycles  = CYC_RET;
            end
            CMD_SEC: reg_p[FLG_C] = 1'b1;
            CMD_SED: reg_p[FLG_D] = 1'b1;
            CMD_SEI: reg_p[FLG_I] = 1'b1;
            CMD_TAX: reg_x = with_zn(reg_a);
            CMD_TAY: reg_y = with_zn(reg_a);
            CMD_TSX: reg_x = with_zn(reg_s);
            CMD_TXA: reg_a = with_zn(reg_x);
            CMD_TXS: reg_s = reg_x;
            CMD_TYA: reg_a = with_zn(reg_y);
            default: ;
        endcase
        r.acc   = reg_a;
        r.x     = reg_x;
        r.y     = reg_y;
        r.sp    = reg_s;
        r.flags = reg_p;
        return r;
    endfunction

    function automatic void plan(input logic [CMD_W-1:0] c, input logic [PC_W-1:0] pc,
                                 input bit typed, input t_retire want);
        t_dir_row row;
        row.cmd   = c;
        row.pc    = pc;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void cmp_field(input string name, input logic [PC_W-1:0] want,
                                      input logic [PC_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            bad_fields++;
        end
    endfunction

    // one instruction beat on the input channel, predicted when it is taken
    task automatic issue(input logic [CMD_W-1:0] c, input logic [PC_W-1:0] pc,
                         input bit typed, input t_retire want);
        t_retire model;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= c;
        i_pc_in    <= pc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model = exec_implied(c, pc);
        expected_regs.push_back(typed ? want : model);
    endtask

    // vector write only once every result is back
    task automatic load_vector(input logic [PC_W-1:0] v);
        i_in_valid <= 1'b0;
        while (expected_regs.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        brk_vec = v;
    endtask

    task automatic random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                input logic [PC_W-1:0] vec);
        logic [CMD_W-1:0] c;
        logic [PC_W-1:0]  pc;
        load_vector(vec);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 8)
                c = CMD_W'($urandom_range(CMD_UNUSED_TOP, CMD_UNUSED_LO));
            else
                c = CMD_W'($urandom_range(CMD_TYA, CMD_BRK));
            // addresses near the top of memory exercise the wrap
            if ($urandom_range(7) == 0)
                pc = {8'hFF, 8'($urandom_range(255))};
            else
                pc = PC_W'($urandom_range(65535));
            issue(c, pc, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_retire e;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_regs.size() == 0) begin
                $error("result beat with nothing expected, pc_next %0h", o_pc_next);
                bad_fields++;
            end else begin
                e = expected_regs.pop_front();
                cmp_field("acc_out", PC_W'(e.acc), PC_W'(o_acc_out));
                cmp_field("x_out", PC_W'(e.x), PC_W'(o_x_out));
                cmp_field("y_out", PC_W'(e.y), PC_W'(o_y_out));
                cmp_field("sp_out", PC_W'(e.sp), PC_W'(o_sp_out));
                cmp_field("flags_out", PC_W'(e.flags), PC_W'(o_flags_out));
                cmp_field("pc_next", e.pc_next, o_pc_next);
                cmp_field("cycle_count", PC_W'(e.cycles), PC_W'(o_cycle_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_ticks++;
        if (cycle_ticks > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_NOP;
        i_pc_in      = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        reg_a        = '0;
        reg_x        = '0;
        reg_y        = '0;
        reg_s        = SP_RST;
        reg_p        = STATUS_RST;
        brk_vec      = VEC_RST;
        foreach (stack_ram[k]) stack_ram[k] = '0;
        bad_fields   = 0;
        cycle_ticks  = 0;
        src_idle_pct = 12;
        snk_idle_pct = 81;

        // state right after reset, flag updates and 8/16-bit wraps
        plan(CMD_NOP, 16'h0000, 1'b1,
             {8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 16'h0001, CYC_IMPL});
        plan(CMD_DEX, 16'hFFFF, 1'b1,
             {8'h00, 8'hFF, 8'h00, 8'hFD, 8'hA4, 16'h0000, CYC_IMPL});
        plan(CMD_INX, 16'h1234, 1'b1,
             {8'h00, 8'h00, 8'h00, 8'hFD, 8'h26, 16'h1235, CYC_IMPL});
        plan(CMD_DEY, 16'h0100, 1'b1,
             {8'h00, 8'h00, 8'hFF, 8'hFD, 8'hA4, 16'h0101, CYC_IMPL});
        plan(CMD_INY, 16'h0101, 1'b1,
             {8'h00, 8'h00, 8'h00, 8'hFD, 8'h26, 16'h0102, CYC_IMPL});
        plan(CMD_PLA, 16'h0200, 1'b1,
             {8'h00, 8'h00, 8'h00, 8'hFE, 8'h26, 16'h0201, CYC_PULL});
        // load all-ones into the status through the stack (B dropped), then walk the flags
        plan(CMD_DEX, 16'h0201, 1'b0, '0);
        plan(CMD_TXA, 16'h0202, 1'b0, '0);
        plan(CMD_PHA, 16'h0203, 1'b0, '0);
        plan(CMD_PLP, 16'h0204, 1'b0, '0);
        plan(CMD_CLV, 16'h0205, 1'b0, '0);
        plan(CMD_CLC, 16'h0206, 1'b0, '0);
        plan(CMD_CLD, 16'h0207, 1'b0, '0);
        plan(CMD_CLI, 16'h0208, 1'b0, '0);
        plan(CMD_SEC, 16'h0209, 1'b0, '0);
        plan(CMD_SED, 16'h020A, 1'b0, '0);
        plan(CMD_SEI, 16'h020B, 1'b0, '0);
        // sp to ff, then a push at the top of the stack page
        plan(CMD_TXS, 16'h020C, 1'b0, '0);
        plan(CMD_TSX, 16'h020D, 1'b0, '0);
        plan(CMD_PHP, 16'h020E, 1'b0, '0);
        plan(CMD_TAY, 16'h020F, 1'b0, '0);
        plan(CMD_TYA, 16'h0210, 1'b0, '0);
        plan(CMD_TAX, 16'h0211, 1'b0, '0);
        // return address wraps past ffff
        plan(CMD_BRK, 16'hFFFE, 1'b0, '0);
        plan(CMD_RTI, 16'h8000, 1'b0, '0);
        plan(CMD_BRK, 16'h7FFF, 1'b0, '0);
        plan(CMD_RTS, 16'h0000, 1'b0, '0);
        plan(CMD_UNUSED_TOP, 16'hFFFF, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_vector(16'hFFFF);
        foreach (directed_rows[i])
            issue(directed_rows[i].cmd, directed_rows[i].pc,
                  directed_rows[i].typed, directed_rows[i].want);

        random_phase(12, 81, PC_W'($urandom_range(65535)));
        random_phase(81, 12, 16'h0000);
        random_phase(0, 0, PC_W'($urandom_range(65535)));

        i_in_valid <= 1'b0;
        while (expected_regs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_fields == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
